// ===== sv/mhtq_pkg.sv =====
package mhtq_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ID_W     = 32;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned OCNT_W   = 7;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [ID_W-1:0]  timer_id;
    logic [KEY_W-1:0] end_time;
  } mhtq_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              heap_empty;
    logic [ID_W-1:0]   top_timer_id;
    logic [KEY_W-1:0]  top_end_time;
    logic [OCNT_W-1:0] entry_count;
  } mhtq_out_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } heap_entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SRCH_RD,
    OP_SRCH_NEXT,
    OP_DEL_START,
    OP_DEL_LOAD,
    OP_INS_START,
    OP_UP_RD,
    OP_UP_MOVE,
    OP_DN_RD,
    OP_DN_MOVE,
    OP_PUT_CUR,
    OP_TOP_RD,
    OP_OUT_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       set_status;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic req_insert;
    logic req_remove;
    logic idx_end;
    logic id_match;
    logic replace;
    logic full;
    logic del_last;
    logic hole_zero;
    logic up_move;
    logic dn_move;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== sv/mhtq_datapath.sv =====
module mhtq_datapath
  import mhtq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mhtq_in_t  in_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_data_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output mhtq_out_t out_data_o,
  input  dp_cmd_t   cmd_i,
  output dp_stat_t  stat_o
);

  heap_entry_t mem [CAPACITY];

  mhtq_in_t         req_q;
  logic [CNT_W-1:0] size_q, idx_q;
  logic [IDX_W-1:0] hole_q;
  heap_entry_t      cur_q, rd0_q, rd1_q;
  logic [1:0]       status_q;
  logic             replace_q;
  logic             out_valid_q;
  mhtq_out_t        out_q;

  logic [IDX_W-1:0] raddr0, raddr1, parent, child_idx;
  logic [IDX_W+1:0] left_w, right_w, size_w;
  logic             l_ok, r_ok, pick_l, pick_r, we;
  logic [KEY_W-1:0] best_key;
  heap_entry_t      child, wdata;

  assign parent  = (hole_q - IDX_W'(1)) >> 1;
  assign left_w  = {1'b0, hole_q, 1'b1};
  assign right_w = left_w + (IDX_W+2)'(1);
  assign size_w  = (IDX_W+2)'(size_q);
  assign l_ok    = left_w < size_w;
  assign r_ok    = right_w < size_w;

  always_comb begin
    pick_l   = 1'b0;
    pick_r   = 1'b0;
    best_key = cur_q.key;
    if (l_ok && rd0_q.key < best_key) begin
      pick_l   = 1'b1;
      best_key = rd0_q.key;
    end
    if (r_ok && rd1_q.key < best_key) begin
      pick_l = 1'b0;
      pick_r = 1'b1;
    end
  end

  assign child     = pick_r ? rd1_q : rd0_q;
  assign child_idx = pick_r ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];

  always_comb begin
    raddr0 = '0;
    raddr1 = '0;
    we     = 1'b0;
    wdata  = cur_q;
    case (cmd_i.op)
      OP_SRCH_RD:   raddr0 = idx_q[IDX_W-1:0];
      OP_DEL_START: raddr0 = IDX_W'(size_q - CNT_W'(1));
      OP_UP_RD:     raddr0 = parent;
      OP_DN_RD: begin
        raddr0 = left_w[IDX_W-1:0];
        raddr1 = right_w[IDX_W-1:0];
      end
      OP_UP_MOVE: begin
        we    = 1'b1;
        wdata = rd0_q;
      end
      OP_DN_MOVE: begin
        we    = 1'b1;
        wdata = child;
      end
      OP_PUT_CUR:   we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[hole_q] <= wdata;
    end
    rd0_q <= mem[raddr0];
    rd1_q <= mem[raddr1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= '0;
      idx_q       <= '0;
      hole_q      <= '0;
      status_q    <= ST_OK;
      replace_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        replace_q <= cfg_data_i;
      end
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
      if (cmd_i.op == OP_OUT_LOAD) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LATCH: begin
          idx_q    <= '0;
          status_q <= ST_OK;
        end
        OP_SRCH_NEXT: idx_q <= idx_q + CNT_W'(1);
        OP_DEL_START: begin
          size_q <= size_q - CNT_W'(1);
          hole_q <= idx_q[IDX_W-1:0];
        end
        OP_INS_START: begin
          size_q <= size_q + CNT_W'(1);
          hole_q <= size_q[IDX_W-1:0];
        end
        OP_UP_MOVE: hole_q <= parent;
        OP_DN_MOVE: hole_q <= child_idx;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) begin
      req_q <= in_data_i;
    end
    case (cmd_i.op)
      OP_DEL_LOAD:  cur_q <= rd0_q;
      OP_INS_START: cur_q <= '{id: req_q.timer_id, key: req_q.end_time};
      default: ;
    endcase
    if (cmd_i.op == OP_OUT_LOAD) begin
      out_q.status       <= status_q;
      out_q.heap_empty   <= (size_q == '0);
      out_q.top_timer_id <= (size_q != '0) ? rd0_q.id : '0;
      out_q.top_end_time <= (size_q != '0) ? rd0_q.key : '0;
      out_q.entry_count  <= OCNT_W'(size_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.req_insert = (req_q.req_type == REQ_INSERT);
  assign stat_o.req_remove = (req_q.req_type == REQ_REMOVE);
  assign stat_o.idx_end    = (idx_q == size_q);
  assign stat_o.id_match   = (rd0_q.id == req_q.timer_id);
  assign stat_o.replace    = replace_q;
  assign stat_o.full       = (size_q == CNT_W'(CAPACITY));
  assign stat_o.del_last   = (idx_q == size_q - CNT_W'(1));
  assign stat_o.hole_zero  = (hole_q == '0);
  assign stat_o.up_move    = (rd0_q.key > cur_q.key);
  assign stat_o.dn_move    = pick_l | pick_r;
  assign stat_o.out_busy   = out_valid_q & ~out_ready_i;

`ifndef NO_ASSERTIONS
  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= CNT_W'(CAPACITY))
    else $error("heap size beyond capacity");
  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (CNT_W'(hole_q) < size_q))
    else $error("heap write outside stored entries");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_OUT_LOAD) |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten before it was taken");
  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SRCH_NEXT) |-> (idx_q < size_q))
    else $error("search ran past the last entry");
`endif

endmodule

// ===== sv/mhtq_ctrl.sv =====
module mhtq_ctrl
  import mhtq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DEL_LD,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_FINISH,
    S_OUT_LD
  } state_e;

  state_e state_q, state_d;
  logic   ins_pend_q, ins_pend_d;

  always_comb begin
    state_d          = state_q;
    ins_pend_d       = ins_pend_q;
    cmd_o.op         = OP_NONE;
    cmd_o.set_status = 1'b0;
    cmd_o.status     = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op   = OP_LATCH;
          ins_pend_d = 1'b0;
          state_d    = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (!stat_i.req_insert && !stat_i.req_remove) begin
          state_d = S_FINISH;
        end else if (stat_i.idx_end) begin
          if (stat_i.req_insert && stat_i.full) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_FULL;
            state_d          = S_FINISH;
          end else if (stat_i.req_insert) begin
            cmd_o.op = OP_INS_START;
            state_d  = S_UP_CHK;
          end else begin
            state_d = S_FINISH;
          end
        end else begin
          cmd_o.op = OP_SRCH_RD;
          state_d  = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (!stat_i.id_match) begin
          cmd_o.op = OP_SRCH_NEXT;
          state_d  = S_SRCH_RD;
        end else if (stat_i.req_insert && !stat_i.replace) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_DUP;
          state_d          = S_FINISH;
        end else begin
          cmd_o.op   = OP_DEL_START;
          ins_pend_d = stat_i.req_insert;
          state_d    = stat_i.del_last ? S_FINISH : S_DEL_LD;
        end
      end
      S_DEL_LD: begin
        cmd_o.op = OP_DEL_LOAD;
        state_d  = S_UP_CHK;
      end
      S_UP_CHK: begin
        if (stat_i.hole_zero) begin
          state_d = S_DN_RD;
        end else begin
          cmd_o.op = OP_UP_RD;
          state_d  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_move) begin
          cmd_o.op = OP_UP_MOVE;
          state_d  = S_UP_CHK;
        end else begin
          state_d = S_DN_RD;
        end
      end
      S_DN_RD: begin
        cmd_o.op = OP_DN_RD;
        state_d  = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat_i.dn_move) begin
          cmd_o.op = OP_DN_MOVE;
          state_d  = S_DN_RD;
        end else begin
          cmd_o.op = OP_PUT_CUR;
          state_d  = S_FINISH;
        end
      end
      S_FINISH: begin
        // A replacing insert appends the new entry once the old one is gone.
        if (ins_pend_q) begin
          cmd_o.op   = OP_INS_START;
          ins_pend_d = 1'b0;
          state_d    = S_UP_CHK;
        end else begin
          cmd_o.op = OP_TOP_RD;
          state_d  = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_OUT_LOAD;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ins_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ins_pend_q <= ins_pend_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

`ifndef NO_ASSERTIONS
  a_pend_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_pend_q |-> stat_i.req_insert)
    else $error("pending insert without an insert request");
  a_accept_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_SRCH_RD))
    else $error("accepted request did not start");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_OUT_LOAD) |=> in_ready_o)
    else $error("no return to idle after result");
`endif

endmodule

// ===== sv/min_heap_timer_queue.sv =====
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   in_data_i  (mhtq_in_t)
// out      output     out_valid_o / out_ready_i out_data_o (mhtq_out_t)
// cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (replace_duplicate)
//
// One request at a time. The id search examines the stored entries one by one
// and each sift moves one level per step; a replacing insert removes the old
// entry before it appends the new one.
// Reset empties the heap and sets replace_duplicate; no clearing pass.
// A waiting result sits in the output register; the next request is taken
// meanwhile and stalls only at its own result load.
module min_heap_timer_queue
  import mhtq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mhtq_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mhtq_out_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  mhtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mhtq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ===== verif/tb.sv =====
module tb
  import mhtq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  mhtq_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  mhtq_out_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i = 1'b0;

  min_heap_timer_queue u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow heap used to predict each response.
  heap_entry_t shadow_heap[CAPACITY];
  int unsigned shadow_size;
  logic        shadow_replace;

  mhtq_in_t  pending_reqs[$];
  mhtq_out_t expected_resps[$];
  int        error_count = 0;
  int        sent_count = 0;
  bit        stim_done = 1'b0;
  bit        hold_sink = 1'b0;
  bit        pause_source = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic void add_req(mhtq_in_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic void heap_swap(int unsigned a, int unsigned b);
    heap_entry_t t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  function automatic void heap_rise(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (shadow_heap[p].key <= shadow_heap[i].key) break;
      heap_swap(p, i);
      i = p;
    end
  endfunction

  function automatic void heap_sink(int unsigned i);
    int unsigned l, r, m;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < shadow_size && shadow_heap[l].key < shadow_heap[m].key) m = l;
      if (r < shadow_size && shadow_heap[r].key < shadow_heap[m].key) m = r;
      if (m == i) break;
      heap_swap(i, m);
      i = m;
    end
  endfunction

  function automatic int unsigned heap_find(logic [ID_W-1:0] id);
    for (int unsigned i = 0; i < shadow_size; i++)
      if (shadow_heap[i].id == id) return i;
    return shadow_size;
  endfunction

  function automatic void heap_delete(int unsigned k);
    shadow_size--;
    if (k != shadow_size) begin
      shadow_heap[k] = shadow_heap[shadow_size];
      heap_rise(k);
      heap_sink(k);
    end
  endfunction

  function automatic mhtq_out_t apply_timer_req(mhtq_in_t req);
    mhtq_out_t   resp;
    int unsigned k;
    resp = '0;
    resp.status = ST_OK;
    if (req.req_type == REQ_INSERT) begin
      k = heap_find(req.timer_id);
      if (k < shadow_size) begin
        if (shadow_replace) heap_delete(k);
        else resp.status = ST_DUP;
      end
      if (resp.status == ST_OK) begin
        if (shadow_size >= CAPACITY) begin
          resp.status = ST_FULL;
        end else begin
          shadow_heap[shadow_size] = '{id: req.timer_id, key: req.end_time};
          shadow_size++;
          heap_rise(shadow_size - 1);
        end
      end
    end else if (req.req_type == REQ_REMOVE) begin
      k = heap_find(req.timer_id);
      if (k < shadow_size) heap_delete(k);
    end
    resp.heap_empty = (shadow_size == 0);
    if (shadow_size != 0) begin
      resp.top_timer_id = shadow_heap[0].id;
      resp.top_end_time = shadow_heap[0].key;
    end
    resp.entry_count = shadow_size[OCNT_W-1:0];
    return resp;
  endfunction

  // Driver: one request per transaction, with random gaps.
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      expected_resps = {expected_resps, apply_timer_req(in_data_i)};
      sent_count++;
    end
    if (!(in_valid_i && !in_ready_o)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0 && !pause_source && rst_ni) begin
        in_data_i <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                                : $urandom_range(0, 2);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks each response transaction and randomizes ready.
  always @(posedge clk_i) begin
    mhtq_out_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_resps.size() == 0) begin
        report_mismatch("unexpected response", 64'(out_data_o.top_timer_id), 64'd0);
      end else begin
        want = expected_resps.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", 64'(out_data_o.status), 64'(want.status));
        if (out_data_o.heap_empty !== want.heap_empty)
          report_mismatch("heap_empty", 64'(out_data_o.heap_empty),
                          64'(want.heap_empty));
        if (out_data_o.top_timer_id !== want.top_timer_id)
          report_mismatch("top_timer_id", 64'(out_data_o.top_timer_id),
                          64'(want.top_timer_id));
        if (out_data_o.top_end_time !== want.top_end_time)
          report_mismatch("top_end_time", 64'(out_data_o.top_end_time),
                          64'(want.top_end_time));
        if (out_data_o.entry_count !== want.entry_count)
          report_mismatch("entry_count", 64'(out_data_o.entry_count),
                          64'(want.entry_count));
      end
    end
    if (hold_sink) out_ready_i <= 1'b0;
    else if ($urandom_range(0, 19) == 0) out_ready_i <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_ready_i <= ~out_ready_i;
    else out_ready_i <= 1'b1;
  end

  task automatic write_replace_mode(input logic value);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    shadow_replace = value;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid_i || expected_resps.size() > 0)
      @(posedge clk_i);
  endtask

  function automatic mhtq_in_t make_req(logic [1:0] kind, logic [31:0] id,
                                        logic [31:0] t);
    mhtq_in_t r;
    r.req_type = kind;
    r.timer_id = id;
    r.end_time = t;
    return r;
  endfunction

  // Ids come from a small pool most of the time so that duplicates and
  // removes of stored timers are frequent.
  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 80);
    endcase
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      2: return 32'h0;
      default: return $urandom_range(0, 50);
    endcase
  endfunction

  task automatic queue_random(input int count, input int insert_weight);
    logic [1:0] kind;
    int unsigned roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < insert_weight) kind = REQ_INSERT;
      else if (roll < 90) kind = REQ_REMOVE;
      else if (roll < 96) kind = REQ_QUERY;
      else kind = REQ_UNUSED;
      add_req(make_req(kind, pick_id(), pick_time()));
    end
  endtask

  initial begin
    shadow_size = 0;
    shadow_replace = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty heap, extremes, ties, unused code, absent remove.
    add_req(make_req(REQ_QUERY, 32'h0, 32'h0));
    add_req(make_req(REQ_REMOVE, 32'h5, 32'h0));
    add_req(make_req(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_req(make_req(REQ_INSERT, 32'h0, 32'h0));
    add_req(make_req(REQ_INSERT, 32'h1234_5678, 32'h0));
    add_req(make_req(REQ_INSERT, 32'h0, 32'hAAAA_5555));
    add_req(make_req(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_req(make_req(REQ_REMOVE, 32'h1234_5678, 32'h0));
    add_req(make_req(REQ_REMOVE, 32'h7777, 32'hFFFF_FFFF));
    add_req(make_req(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0));
    add_req(make_req(REQ_REMOVE, 32'h0, 32'h0));
    add_req(make_req(REQ_QUERY, 32'h5555_AAAA, 32'h5555_AAAA));
    wait_drained();
    write_replace_mode(1'b0);
    add_req(make_req(REQ_INSERT, 32'h9, 32'h10));
    add_req(make_req(REQ_INSERT, 32'h9, 32'h1));
    add_req(make_req(REQ_REMOVE, 32'h9, 32'h0));
    wait_drained();

    // Fill to capacity with ties, then overflow, under both modes.
    for (int i = 0; i < CAPACITY + 3; i++)
      add_req(make_req(REQ_INSERT, 32'h100 + i, $urandom_range(0, 3)));
    add_req(make_req(REQ_INSERT, 32'h100, 32'h2));
    wait_drained();
    write_replace_mode(1'b1);
    add_req(make_req(REQ_INSERT, 32'h105, 32'h0));
    add_req(make_req(REQ_INSERT, 32'hDEAD, 32'h0));
    for (int i = 0; i < CAPACITY; i++)
      add_req(make_req(REQ_REMOVE, 32'h100 + i, 32'h0));

    // Long receiver stall while requests keep coming.
    hold_sink = 1'b1;
    queue_random(20, 60);
    repeat (400) @(posedge clk_i);
    hold_sink = 1'b0;
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      write_replace_mode(phase[0]);
      queue_random(110, (phase == 2) ? 75 : 55);
      // Pause the source until every response has come back.
      while (pending_reqs.size() > 55) @(posedge clk_i);
      pause_source = 1'b1;
      while (in_valid_i || expected_resps.size() > 0) @(posedge clk_i);
      pause_source = 1'b0;
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (error_count == 0 && expected_resps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
